// ===== rtl/rng_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rng_pkg: replay nonce guard shared types and constants
// Field widths, table geometry, status codes and the request, result and
// table row structures used by the guard and its submodules.
// ----------------------------------------------------------------------------
package rng_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int PURGE_LIMIT = 768;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int TIME_W      = 47;
	localparam int EXP_W       = TIME_W + 1;
	localparam int NONCE_W     = 64;
	localparam int CFG_W       = 16;
	localparam int MS_PER_SEC  = 1000;
	localparam int WIN_W       = 26;
	localparam int WIN_RESET   = 60 * MS_PER_SEC;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_WINDOW = 2'd1,
		ST_REPLAY = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0]  current_time;
		logic [TIME_W-1:0]  msg_time;
		logic [NONCE_W-1:0] msg_nonce;
	} req_t;

	typedef struct packed {
		logic    accepted;
		status_t status;
	} res_t;

	typedef struct packed {
		logic               valid;
		logic [EXP_W-1:0]   expiry;
		logic [NONCE_W-1:0] nonce;
	} row_t;

	typedef struct packed {
		logic hit;
		logic free;
		logic stale;
	} cmp_t;

endpackage : rng_pkg
`default_nettype wire

// ===== rtl/rng_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rng_mem: nonce table storage
// One write port and one read port with registered read data; each row holds
// the valid mark, expiry time and nonce of one table slot.
// ----------------------------------------------------------------------------
module rng_mem
	import rng_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire row_t              wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output row_t                   rd_data
);

	row_t mem_q [TABLE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule : rng_mem
`default_nettype wire

// ===== rtl/rng_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rng_cmp: shared row compare unit
// Checks one table row against the request nonce and the present time:
// nonce match, free slot, and expiry earlier than now.
// ----------------------------------------------------------------------------
module rng_cmp
	import rng_pkg::*;
(
	input  wire row_t               row,
	input  wire logic [NONCE_W-1:0] key,
	input  wire logic [TIME_W-1:0]  now,
	output cmp_t                    res
);

	// one equality and one magnitude compare per row
	always_comb begin
		res.hit   = row.valid && (row.nonce == key);
		res.free  = !row.valid;
		res.stale = row.valid && (row.expiry < {1'b0, now});
	end

endmodule : rng_cmp
`default_nettype wire

// ===== rtl/replay_nonce_guard.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// replay_nonce_guard: timestamp window and nonce replay check
// Steps: a timestamp outside the window is rejected at the window check;
// otherwise the window check is followed by the table scan, which ends early
// on a replay, then the insert and, when the count passes the purge limit,
// the purge walk. One request at a time; the scan and the purge walk share
// the single table read port. After reset a clearing pass writes every table
// row with busy high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module replay_nonce_guard
	import rng_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire req_t             req,
	output logic                  done,
	output res_t                  result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WIN,
		S_SCAN,
		S_INSERT,
		S_PURGE
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

	state_t             state_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               issue_done_q;
	logic               pend_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [CNT_W-1:0]   count_q;
	logic [WIN_W-1:0]   win_ms_q;
	logic               free_found_q;
	logic [ADDR_W-1:0]  free_slot_q;
	logic               done_q;
	res_t               result_q;
	req_t               req_q;
	logic [EXP_W-1:0]   exp_q;

	logic               rd_en;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	row_t               wr_data;
	row_t               rd_data;
	cmp_t               cmp;

	logic [EXP_W-1:0]   lo_sum;
	logic [EXP_W-1:0]   hi_sum;
	logic               out_win;
	logic               last_issue;
	logic               last_pend;
	logic [CNT_W-1:0]   cnt_inc;
	logic [WIN_W-1:0]   win_next;

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

	// window bounds and expiry of a new entry
	assign lo_sum  = {1'b0, req_q.msg_time} + EXP_W'(win_ms_q);
	assign hi_sum  = {1'b0, req_q.current_time} + EXP_W'(win_ms_q);
	assign out_win = (lo_sum < {1'b0, req_q.current_time}) ||
	                 ({1'b0, req_q.msg_time} > hi_sum);

	assign last_issue = (addr_q == LAST_ADDR);
	assign last_pend  = (addr_s1 == LAST_ADDR);
	assign cnt_inc    = count_q + CNT_W'(1);
	assign win_next   = WIN_W'(cfg_data) * WIN_W'(MS_PER_SEC);

	// table port control
	always_comb begin
		rd_en   = ((state_q == S_SCAN) || (state_q == S_PURGE)) && !issue_done_q;
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_INSERT: begin
				wr_en   = free_found_q;
				wr_addr = free_slot_q;
				wr_data = '{valid: 1'b1, expiry: exp_q, nonce: req_q.msg_nonce};
			end
			S_PURGE: begin
				wr_en         = pend_s1 && cmp.stale;
				wr_addr       = addr_s1;
				wr_data       = rd_data;
				wr_data.valid = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	rng_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	rng_cmp u_cmp (
		.row (rd_data),
		.key (req_q.msg_nonce),
		.now (req_q.current_time),
		.res (cmp)
	);

	// sequencer, counters and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			pend_s1      <= 1'b0;
			count_q      <= '0;
			win_ms_q     <= WIN_W'(WIN_RESET);
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
			result_q     <= '{accepted: 1'b0, status: ST_OK};
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				win_ms_q <= win_next;
			end
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (last_issue) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					addr_q       <= '0;
					issue_done_q <= 1'b0;
					pend_s1      <= 1'b0;
					free_found_q <= 1'b0;
					if (out_win) begin
						result_q <= '{accepted: 1'b0, status: ST_WINDOW};
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!issue_done_q) begin
						addr_q <= addr_q + ADDR_W'(1);
						if (last_issue) begin
							issue_done_q <= 1'b1;
						end
					end
					pend_s1 <= !issue_done_q;
					if (pend_s1) begin
						if (cmp.hit) begin
							result_q <= '{accepted: 1'b0, status: ST_REPLAY};
							done_q   <= 1'b1;
							pend_s1  <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							if (cmp.free) begin
								free_found_q <= 1'b1;
							end
							if (last_pend) begin
								pend_s1 <= 1'b0;
								state_q <= S_INSERT;
							end
						end
					end
				end
				S_INSERT: begin
					addr_q       <= '0;
					issue_done_q <= 1'b0;
					pend_s1      <= 1'b0;
					if (!free_found_q) begin
						result_q <= '{accepted: 1'b0, status: ST_FULL};
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						count_q <= cnt_inc;
						if (cnt_inc > CNT_W'(PURGE_LIMIT)) begin
							state_q <= S_PURGE;
						end else begin
							result_q <= '{accepted: 1'b1, status: ST_OK};
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end
				S_PURGE: begin
					if (!issue_done_q) begin
						addr_q <= addr_q + ADDR_W'(1);
						if (last_issue) begin
							issue_done_q <= 1'b1;
						end
					end
					pend_s1 <= !issue_done_q;
					if (pend_s1) begin
						if (cmp.stale) begin
							count_q <= count_q - CNT_W'(1);
						end
						if (last_pend) begin
							result_q <= '{accepted: 1'b1, status: ST_OK};
							done_q   <= 1'b1;
							pend_s1  <= 1'b0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture and scan payload
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if ((state_q == S_IDLE) && start) begin
			req_q <= req;
		end
		if (state_q == S_WIN) begin
			exp_q <= hi_sum;
		end
		if ((state_q == S_SCAN) && pend_s1 && cmp.free && !free_found_q) begin
			free_slot_q <= addr_s1;
		end
	end

	// result strobe is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// accepted flag agrees with status
	a_acc_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.accepted == (result.status == ST_OK)))
		else $error("accepted flag and status disagree");

	// entry count never passes table depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// an accepted request keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request transfer did not raise busy");

	// a purge only follows an insert over the limit
	a_purge_entry: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_PURGE) && ($past(state_q) != S_PURGE)) |->
		(count_q > CNT_W'(PURGE_LIMIT)))
		else $error("purge walk entered below limit");

endmodule : replay_nonce_guard
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: replay nonce guard testbench
// Drives requests through the start/busy port and predicts each verdict with
// a cycle-free table model of the guard. Covers window edges, zero and widest
// windows, stale replays, then mixed random traffic under three sender idle
// settings.
// ----------------------------------------------------------------------------
module tb_top;
	import rng_pkg::*;

	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int RANDOM_PER_PHASE = 90;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	// predicted guard state
	logic [NONCE_W-1:0] tbl_nonce [TABLE_DEPTH];
	logic [EXP_W-1:0] tbl_expiry [TABLE_DEPTH];
	bit tbl_valid [TABLE_DEPTH];
	int live_count = 0;
	logic [CFG_W-1:0] guard_window = 16'd60;

	res_t pending_verdicts [$];
	logic [NONCE_W-1:0] nonce_log [$];

	int sender_idle_pct = 0;
	int mismatch_count = 0;
	int checked_count = 0;
	int cycle_count = 0;
	int status_tally [4] = '{0, 0, 0, 0};
	int purge_walks = 0;
	int purged_total = 0;
	int window_writes = 0;

	// clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	replay_nonce_guard u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// verdict predictor, updates the table copy as the guard would
	task automatic predict_verdict(input req_t r);
		logic [63:0] now;
		logic [63:0] stamp;
		logic [63:0] span;
		res_t verdict;
		int slot;
		bit known;
		now = 64'(r.current_time);
		stamp = 64'(r.msg_time);
		span = 64'(guard_window) * 64'(MS_PER_SEC);
		verdict.accepted = 1'b0;
		verdict.status = ST_OK;
		slot = -1;
		known = 1'b0;
		if (stamp + span < now || stamp > now + span) begin
			verdict.status = ST_WINDOW;
		end else begin
			// expired entries still count until purged
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (tbl_valid[i] && tbl_nonce[i] == r.msg_nonce)
					known = 1'b1;
			end
			if (known) begin
				verdict.status = ST_REPLAY;
			end else begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (!tbl_valid[i]) begin
						slot = i;
						break;
					end
				end
				if (slot < 0) begin
					verdict.status = ST_FULL;
				end else begin
					tbl_nonce[slot] = r.msg_nonce;
					tbl_expiry[slot] = EXP_W'(now + span);
					tbl_valid[slot] = 1'b1;
					live_count++;
					verdict.accepted = 1'b1;
					// purge walk once the count passes the limit
					if (live_count > PURGE_LIMIT) begin
						purge_walks++;
						for (int i = 0; i < TABLE_DEPTH; i++) begin
							if (tbl_valid[i] && 64'(tbl_expiry[i]) < now) begin
								tbl_valid[i] = 1'b0;
								live_count--;
								purged_total++;
							end
						end
					end
				end
			end
		end
		status_tally[verdict.status]++;
		pending_verdicts.push_back(verdict);
	endtask

	function automatic logic [NONCE_W-1:0] fresh_nonce();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [TIME_W-1:0] any_time();
		return TIME_W'({$urandom, $urandom});
	endfunction

	// timestamp at a given distance from now, on the requested side if it fits
	function automatic logic [TIME_W-1:0] stamp_at(input logic [TIME_W-1:0] now,
			input int unsigned gap_ms, input bit up);
		logic [63:0] base;
		base = 64'(now);
		if (up && base + gap_ms <= 64'(TIME_MAX))
			return TIME_W'(base + gap_ms);
		if (base >= gap_ms)
			return TIME_W'(base - gap_ms);
		return TIME_W'(base + gap_ms);
	endfunction

	function automatic logic [NONCE_W-1:0] logged_nonce();
		return nonce_log[$urandom_range(0, nonce_log.size() - 1)];
	endfunction

	// one request transfer, with an optional idle gap in front
	task automatic issue_request(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] stamp, input logic [NONCE_W-1:0] nonce);
		req_t item;
		item.current_time = now;
		item.msg_time = stamp;
		item.msg_nonce = nonce;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		predict_verdict(item);
		nonce_log.push_back(nonce);
	endtask

	task automatic await_results();
		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// window register write, only with the guard idle
	task automatic set_window(input logic [CFG_W-1:0] secs);
		await_results();
		cfg_valid <= 1'b1;
		cfg_data <= secs;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		guard_window = secs;
		window_writes++;
	endtask

	// result checker, one strobe per verdict
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			checked_count++;
			if (pending_verdicts.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result %0d: accepted %0b status %0d",
						checked_count, result.accepted, result.status);
				mismatch_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (result.accepted !== want.accepted || result.status !== want.status) begin
					if (mismatch_count < 10)
						$display("result %0d: accepted exp %0b got %0b, status exp %0d got %0d",
							checked_count, want.accepted, result.accepted,
							want.status, result.status);
					mismatch_count++;
				end
			end
		end
	end

	// reset-value window of 60 s, edges and field extremes
	task automatic test_window_edges();
		logic [TIME_W-1:0] t;
		t = 47'd100_000_000;
		issue_request(t, t, '0);
		issue_request(t, t + 47'd60_000, '1);
		issue_request(t, t - 47'd60_000, 64'h0123_4567_89ab_cdef);
		issue_request(t, t + 47'd60_001, fresh_nonce());
		issue_request(t, t - 47'd60_001, fresh_nonce());
		issue_request(t, t, '0);
		// window check wins over replay
		issue_request(t, t + 47'd60_001, '1);
		issue_request('0, '0, 64'h8000_0000_0000_0001);
		issue_request('0, TIME_MAX, fresh_nonce());
		issue_request(TIME_MAX, TIME_MAX, 64'h7fff_ffff_ffff_fffe);
		issue_request(TIME_MAX, '0, fresh_nonce());
	endtask

	// zero window accepts only an exact timestamp
	task automatic test_zero_window();
		logic [TIME_W-1:0] t;
		t = 47'd77_777_777;
		set_window('0);
		issue_request(t, t, fresh_nonce());
		issue_request(t, t + 47'd1, fresh_nonce());
		issue_request(t, t - 47'd1, fresh_nonce());
	endtask

	// widest window at both ends of the time range
	task automatic test_wide_window();
		set_window('1);
		issue_request(TIME_MAX, TIME_MAX - 47'd65_535_000, fresh_nonce());
		issue_request(TIME_MAX, TIME_MAX - 47'd65_535_001, fresh_nonce());
		issue_request('0, 47'd65_535_000, fresh_nonce());
		issue_request('0, 47'd65_535_001, fresh_nonce());
		issue_request(47'd5, TIME_MAX, fresh_nonce());
	endtask

	// an expired but unpurged nonce is still a replay
	task automatic test_stale_replay();
		logic [NONCE_W-1:0] stale;
		stale = fresh_nonce();
		set_window(16'd1);
		issue_request(47'd1_000, 47'd1_500, stale);
		issue_request(47'd500_000, 47'd500_000, stale);
		issue_request(47'd500_000, 47'd501_000, fresh_nonce());
	endtask

	// mixed traffic under three sender idle settings
	task automatic test_random_traffic();
		logic [TIME_W-1:0] walk_time;
		logic [TIME_W-1:0] now;
		int unsigned span_ms;
		int kind;
		walk_time = TIME_W'({$urandom, $urandom} >> 18);
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 80 : 0;
			case (phase)
				0: set_window(CFG_W'($urandom_range(1, 300)));
				1: set_window(CFG_W'($urandom_range(0, 3)));
				default: set_window(CFG_W'($urandom_range(0, 65535)));
			endcase
			span_ms = guard_window * MS_PER_SEC;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				walk_time = walk_time + TIME_W'($urandom_range(0, 20000));
				now = ($urandom_range(0, 99) < 25) ? any_time() : walk_time;
				kind = $urandom_range(0, 99);
				if (kind < 50) begin
					issue_request(now, stamp_at(now, $urandom_range(0, span_ms),
						1'($urandom_range(0, 1))), fresh_nonce());
				end else if (kind < 70) begin
					issue_request(now, stamp_at(now, $urandom_range(0, span_ms),
						1'($urandom_range(0, 1))), logged_nonce());
				end else if (kind < 85) begin
					// right at or just past the window edge
					issue_request(now, stamp_at(now, span_ms + $urandom_range(0, 1),
						1'($urandom_range(0, 1))),
						$urandom_range(0, 1) ? logged_nonce() : fresh_nonce());
				end else begin
					issue_request(now, any_time(), fresh_nonce());
				end
			end
		end
	endtask

	// cycle count for the run limit
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_window_edges();
		test_zero_window();
		test_wide_window();
		test_stale_replay();
		test_random_traffic();
		await_results();
		repeat (2 * TABLE_DEPTH + 16) @(posedge clk);
		$display("checked %0d verdicts: %0d accepted, %0d outside window, %0d replays, %0d full",
			checked_count, status_tally[ST_OK], status_tally[ST_WINDOW],
			status_tally[ST_REPLAY], status_tally[ST_FULL]);
		$display("%0d purge walks cleared %0d entries; window written %0d times",
			purge_walks, purged_total, window_writes);
		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule : tb_top

// ===== files.f =====
rtl/rng_pkg.sv
rtl/rng_mem.sv
rtl/rng_cmp.sv
rtl/replay_nonce_guard.sv
verif/tb_top.sv
